[rtl/vfp_pkg.sv]
`default_nettype none

package vfp_pkg;

    // field widths
    localparam int unsigned IN_W       = 62;
    localparam int unsigned OUT_W      = 63;
    localparam int unsigned PERIOD_W   = 32;
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 32;

    // register map
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_PERIOD     = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_USE_SERVER_VSYNC = 1'd1;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 32'd16666666;

    // one remainder bit per dividend bit
    localparam int unsigned DIV_STEPS  = IN_W;
    localparam int unsigned STEP_CNT_W = $clog2(DIV_STEPS);

    typedef struct packed {
        logic load;
        logic eval;
        logic step;
        logic emit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic need_div;
        logic out_free;
    } ctrl_status_t;

endpackage

`default_nettype wire

[rtl/vfp_req_if.sv]
`default_nettype none

interface vfp_req_if;
    logic                        valid;
    logic                        ready;
    logic [vfp_pkg::IN_W-1:0]    prev_time;
    logic [vfp_pkg::IN_W-1:0]    now_time;
    logic [vfp_pkg::IN_W-1:0]    server_vsync;

    modport source (output valid, prev_time, now_time, server_vsync, input ready);
    modport sink   (input valid, prev_time, now_time, server_vsync, output ready);
endinterface

`default_nettype wire

[rtl/vfp_rsp_if.sv]
`default_nettype none

interface vfp_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [vfp_pkg::OUT_W-1:0]   target_time;
    logic                        resynced;

    modport source (output valid, target_time, resynced, input ready);
    modport sink   (input valid, target_time, resynced, output ready);
endinterface

`default_nettype wire

[rtl/vfp_cfg_if.sv]
`default_nettype none

interface vfp_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [vfp_pkg::CFG_IDX_W-1:0]   index;
    logic [vfp_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[rtl/vfp_ctrl.sv]
`default_nettype none

module vfp_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  req_valid,
    output logic                       req_ready,
    input  wire vfp_pkg::ctrl_status_t status,
    output vfp_pkg::ctrl_cmd_t         cmd
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EVAL = 4'b0010,
        S_DIV  = 4'b0100,
        S_FIN  = 4'b1000
    } state_t;

    state_t                            state_reg;
    state_t                            state_next;
    logic [vfp_pkg::STEP_CNT_W-1:0]    cnt_reg;
    logic [vfp_pkg::STEP_CNT_W-1:0]    cnt_next;
    logic                              last_step;

    assign last_step = (cnt_reg == vfp_pkg::STEP_CNT_W'(vfp_pkg::DIV_STEPS - 1));

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        req_ready  = 1'b0;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                cmd.eval = 1'b1;
                cnt_next = '0;
                state_next = status.need_div ? S_DIV : S_FIN;
            end
            S_DIV:
            begin
                cmd.step = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (last_step)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

`default_nettype wire

[rtl/vfp_datapath.sv]
`default_nettype none

module vfp_datapath #(
    parameter int unsigned TIME_BITS = 63
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire vfp_pkg::ctrl_cmd_t                cmd,
    output vfp_pkg::ctrl_status_t                  status,
    input  wire logic [vfp_pkg::IN_W-1:0]          prev_time,
    input  wire logic [vfp_pkg::IN_W-1:0]          now_time,
    input  wire logic [vfp_pkg::IN_W-1:0]          server_vsync,
    input  wire logic                              cfg_write,
    input  wire logic [vfp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [vfp_pkg::CFG_DATA_W-1:0]    cfg_data,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic [vfp_pkg::OUT_W-1:0]              target_time,
    output logic                                   resynced
);

    localparam int unsigned IN_W  = vfp_pkg::IN_W;
    localparam int unsigned OUT_W = vfp_pkg::OUT_W;
    localparam int unsigned PW    = vfp_pkg::PERIOD_W;

    // configuration
    logic [PW-1:0]      period_reg;
    logic               use_vsync_reg;
    logic               pending_reg;

    // captured request
    logic [IN_W-1:0]    prev_reg;
    logic [IN_W-1:0]    now_reg;
    logic [IN_W-1:0]    vs_reg;

    // evaluation results
    logic [OUT_W-1:0]   res_reg;
    logic               resync_reg;
    logic               div_flag_reg;

    // remainder unit
    logic [IN_W-1:0]    dvd_reg;
    logic [PW-1:0]      rem_reg;

    // output slot
    logic               out_valid_reg;
    logic [OUT_W-1:0]   out_target_reg;
    logic               out_resync_reg;

    logic [PW-1:0]          p_eff;
    logic [TIME_BITS-1:0]   next_t;
    logic [63:0]            next_wide;
    logic                   late;
    logic                   realign;
    logic                   vs_ahead;
    logic [PW:0]            trial;
    logic                   fits;
    logic [TIME_BITS-1:0]   grid_t;
    logic [63:0]            grid_wide;

    // zero period behaves as one ns
    assign p_eff = (period_reg == '0) ? PW'(1) : period_reg;

    assign next_t    = TIME_BITS'(64'(prev_reg) + 64'(p_eff));
    assign next_wide = 64'(next_t);
    assign late      = (next_wide < 64'(now_reg));
    assign realign   = late | pending_reg;
    assign vs_ahead  = use_vsync_reg & (vs_reg > now_reg);

    assign status.need_div = realign & ~vs_ahead;
    assign status.out_free = ~out_valid_reg | out_ready;

    // restoring step, remainder stays below the period
    assign trial = {rem_reg, dvd_reg[IN_W-1]};
    assign fits  = (trial >= {1'b0, p_eff});

    // first grid edge after now: now - rem + period
    assign grid_t    = TIME_BITS'(64'(now_reg) + 64'(p_eff) - 64'(rem_reg));
    assign grid_wide = 64'(grid_t);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg    <= vfp_pkg::PERIOD_RESET;
            use_vsync_reg <= 1'b0;
            pending_reg   <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write && cfg_index == vfp_pkg::REG_FRAME_PERIOD)
            begin
                period_reg  <= cfg_data;
                pending_reg <= 1'b1;
            end
            else if (cmd.eval && realign)
            begin
                pending_reg <= 1'b0;
            end
            if (cfg_write && cfg_index == vfp_pkg::REG_USE_SERVER_VSYNC)
            begin
                use_vsync_reg <= cfg_data[0];
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            prev_reg <= prev_time;
            now_reg  <= now_time;
            vs_reg   <= server_vsync;
        end
        if (cmd.eval)
        begin
            resync_reg   <= realign;
            div_flag_reg <= status.need_div;
            res_reg      <= realign ? OUT_W'(vs_reg) : next_wide[OUT_W-1:0];
            dvd_reg      <= use_vsync_reg ? (now_reg - vs_reg) : now_reg;
            rem_reg      <= '0;
        end
        else if (cmd.step)
        begin
            dvd_reg <= {dvd_reg[IN_W-2:0], 1'b0};
            rem_reg <= fits ? PW'(trial - {1'b0, p_eff}) : trial[PW-1:0];
        end
        if (cmd.emit)
        begin
            out_target_reg <= div_flag_reg ? grid_wide[OUT_W-1:0] : res_reg;
            out_resync_reg <= resync_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign target_time = out_target_reg;
    assign resynced    = out_resync_reg;

endmodule

`default_nettype wire

[rtl/vsync_frame_pacer.sv]
// a request word is captured and evaluated; when it must be realigned and no supplied vsync
//   lies ahead, the 62-step remainder unit runs before the result word is loaded
// one request in flight: a new request is taken only once the last result word is loaded;
// the output register holds a finished word while the next request is taken
// reset (async, active low): period 16666666 ns, vsync source off, resync pending
`default_nettype none

module vsync_frame_pacer #(
    parameter int unsigned TIME_BITS = 63
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    vfp_req_if.sink       req,
    vfp_rsp_if.source     rsp,
    vfp_cfg_if.sink       cfg
);

    vfp_pkg::ctrl_cmd_t     cmd;
    vfp_pkg::ctrl_status_t  status;
    logic                   cfg_write;

    // register writes are always taken; the host must write only while idle, the block does not enforce it
    assign cfg.ready = 1'b1;
    assign cfg_write = cfg.valid & cfg.ready;

    // sequencer: idle -> evaluate -> remainder steps (only when realigning
    // onto the grid) -> finish, which waits for a free output slot
    vfp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .status    (status),
        .cmd       (cmd)
    );

    // operand capture, lateness check, remainder unit,
    // configuration and pending flag, and the output word register
    vfp_datapath #(
        .TIME_BITS (TIME_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .prev_time    (req.prev_time),
        .now_time     (req.now_time),
        .server_vsync (req.server_vsync),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg.index),
        .cfg_data     (cfg.data),
        .out_valid    (rsp.valid),
        .out_ready    (rsp.ready),
        .target_time  (rsp.target_time),
        .resynced     (rsp.resynced)
    );

    // one request in flight: a taken word closes the request side
    assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> !req.ready)
        else $error("request taken while another is in flight");

    // a finished word shows on the output the cycle after it is loaded
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> rsp.valid)
        else $error("loaded result not presented");

    // a word still waiting must never be overwritten
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.ready |-> !cmd.emit)
        else $error("pending result overwritten");

    // no remainder step while the request side is open
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |-> !req.ready)
        else $error("remainder step while idle");

endmodule

`default_nettype wire
